>>> hdl/cbsot_pkg.sv
// Shared types and constants for the code block sort and overlap trim block.
`timescale 1ns / 1ps
package cbsot_pkg;
    localparam int MaxBlocks = 1024;
    localparam int IdxW = $clog2(MaxBlocks);
    localparam int CntW = IdxW + 1;
    localparam int InDataW = 56;
    localparam int OutDataW = 56;
    localparam logic ActLoad = 1'b0;
    localparam logic ActFetch = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic        compact;
        logic [7:0]  count;
        logic [9:0]  id;
        logic        inner;
    } t_rec;
endpackage

>>> hdl/code_block_sort_and_overlap_trim.sv
// Top level: record store with insertion sort on load, overlap trim pass and fetch port.
`timescale 1ns / 1ps
// Loads (tuser = 0) are kept in sorted order by an insertion that walks the
// store one entry per read-compare pair. The first load of a set is written in
// its accepting cycle, and the block is ready again in the next cycle. Any
// other load keeps the block busy while it moves each stored block whose
// address (then block number) is above the new one up by one place, from the
// end, and writes the new block in the gap, or at the front in a separate
// step. The first fetch after a set of two or more blocks is loaded runs an
// overlap trim pass over each block and its successor. Each fetch then reads
// its entry through the registered memory read; a fetch past the end returns
// nothing. The record memory has one write port and one registered read port.
// The block is not ready while it works or while a result waits to be taken.
module code_block_sort_and_overlap_trim (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // block_address[31:0], compact_mode[32], insn_count[40:33], block_id[50:41]
    input  logic [cbsot_pkg::InDataW-1:0]  i_s_axis_tdata,
    // action[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_block_id[9:0], out_address[41:10], out_compact[42],
    // out_insn_count[50:43], has_inner[51]
    output logic [cbsot_pkg::OutDataW-1:0] o_m_axis_tdata,
    // last_entry
    output logic                           o_m_axis_tlast
);
    import cbsot_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT,
        S_TRIM_RD0, S_TRIM_LD0, S_TRIM_RD, S_TRIM_CMP,
        S_FETCH_RD, S_FETCH_WAIT, S_OUT
    } t_state;

    t_state      r_state;
    logic [CntW-1:0] r_loaded;
    logic [CntW-1:0] r_rdptr;
    logic        r_sorted;
    logic [IdxW-1:0] r_pos;
    t_rec        r_new;
    t_rec        r_cur;
    t_rec        r_rdata;
    t_rec        r_mem [MaxBlocks];
    t_rec        r_out;
    logic        r_last;

    logic [IdxW-1:0] raddr;
    logic        we;
    logic [IdxW-1:0] waddr;
    t_rec        wdata;
    logic        accept;
    logic        new_less;
    logic [31:0] cur_end;
    logic [31:0] gap;
    logic        overlap;
    t_rec        trimmed;
    t_rec        in_rec;
    logic [CntW-1:0] n_loaded;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata = {4'd0, r_out.inner, r_out.count, r_out.compact,
                             r_out.addr, r_out.id};
    assign o_m_axis_tlast = r_last;

    // A load after sorting starts a new set.
    assign n_loaded = r_sorted ? CntW'(0) : r_loaded;

    always_comb begin
        in_rec.addr = {i_s_axis_tdata[31:1], 1'b0};
        in_rec.compact = i_s_axis_tdata[32];
        in_rec.count = i_s_axis_tdata[40:33];
        in_rec.id = i_s_axis_tdata[50:41];
        in_rec.inner = 1'b0;
    end

    // Compare unit: ordering test during insertion.
    assign new_less = (r_new.addr < r_rdata.addr) ||
                      ((r_new.addr == r_rdata.addr) && (r_new.id < r_rdata.id));

    // Overlap test and trimmed count for the current/next pair.
    always_comb begin
        cur_end = r_cur.addr + (r_cur.compact ? {23'd0, r_cur.count, 1'b0}
                                              : {22'd0, r_cur.count, 2'b0});
        overlap = cur_end > r_rdata.addr;
        gap = r_rdata.addr - r_cur.addr;
        trimmed = r_cur;
        if (overlap) begin
            trimmed.inner = 1'b1;
            trimmed.count = r_cur.compact ? gap[8:1] : gap[9:2];
        end
    end

    always_comb begin
        raddr = r_pos;
        we = 1'b0;
        waddr = r_pos;
        wdata = r_new;
        case (r_state)
            S_IDLE: begin
                if (accept && i_s_axis_tuser == ActLoad && r_sorted) begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = in_rec;
                end else if (accept && i_s_axis_tuser == ActLoad &&
                             r_loaded == CntW'(0)) begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = in_rec;
                end
            end
            S_INS_CMP: begin
                we = 1'b1;
                waddr = r_pos + IdxW'(1);
                wdata = new_less ? r_rdata : r_new;
            end
            S_INS_PUT: begin
                we = 1'b1;
                waddr = '0;
                wdata = r_new;
            end
            S_TRIM_RD0: raddr = '0;
            S_TRIM_CMP: begin
                we = 1'b1;
                waddr = r_pos - IdxW'(1);
                wdata = trimmed;
            end
            S_FETCH_RD: raddr = r_rdptr[IdxW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_loaded <= '0;
            r_rdptr <= '0;
            r_sorted <= 1'b0;
            r_pos <= '0;
            r_last <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_s_axis_tuser == ActLoad) begin
                        r_new <= in_rec;
                        r_sorted <= 1'b0;
                        if (r_sorted) r_rdptr <= '0;
                        if (n_loaded == CntW'(0)) begin
                            r_loaded <= CntW'(1);
                        end else if (n_loaded != CntW'(MaxBlocks)) begin
                            r_loaded <= n_loaded;
                            r_pos <= IdxW'(n_loaded - CntW'(1));
                            r_state <= S_INS_RD;
                        end
                    end else if (accept) begin
                        if (r_sorted) begin
                            r_state <= S_FETCH_RD;
                        end else if (r_loaded >= CntW'(2)) begin
                            r_state <= S_TRIM_RD0;
                        end else begin
                            r_sorted <= 1'b1;
                            r_state <= S_FETCH_RD;
                        end
                    end
                end
                S_INS_RD: r_state <= S_INS_CMP;
                S_INS_CMP: begin
                    if (!new_less) begin
                        r_loaded <= r_loaded + CntW'(1);
                        r_state <= S_IDLE;
                    end else if (r_pos == '0) begin
                        r_state <= S_INS_PUT;
                    end else begin
                        r_pos <= r_pos - IdxW'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_PUT: begin
                    r_loaded <= r_loaded + CntW'(1);
                    r_state <= S_IDLE;
                end
                S_TRIM_RD0: r_state <= S_TRIM_LD0;
                S_TRIM_LD0: begin
                    r_cur <= r_rdata;
                    r_pos <= IdxW'(1);
                    r_state <= S_TRIM_RD;
                end
                S_TRIM_RD: r_state <= S_TRIM_CMP;
                S_TRIM_CMP: begin
                    r_cur <= r_rdata;
                    if ({1'b0, r_pos} + CntW'(1) == r_loaded) begin
                        r_sorted <= 1'b1;
                        r_state <= S_FETCH_RD;
                    end else begin
                        r_pos <= r_pos + IdxW'(1);
                        r_state <= S_TRIM_RD;
                    end
                end
                S_FETCH_RD: begin
                    r_state <= (r_rdptr >= r_loaded) ? S_IDLE : S_FETCH_WAIT;
                end
                S_FETCH_WAIT: begin
                    r_out <= r_rdata;
                    r_last <= (r_rdptr + CntW'(1) == r_loaded);
                    r_rdptr <= r_rdptr + CntW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/cbsot_checker.sv
// Port-level checks for the code block sort and overlap trim block, bound to the top level.
`timescale 1ns / 1ps
module cbsot_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [cbsot_pkg::OutDataW-1:0] o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);
    // A held result keeps its payload until the transaction completes.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // The block never takes a new item while a result waits.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("ready while result pending");

    // A load never produces a result.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser |=> !o_m_axis_tvalid)
        else $error("result after load");

    // Nothing is shown right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind code_block_sort_and_overlap_trim cbsot_checker u_cbsot_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the code block sort and overlap trim block.
`timescale 1ns / 1ps
module tb_top;
    import cbsot_pkg::*;

    typedef struct packed {
        logic [9:0]  id;
        logic [31:0] addr;
        logic        compact;
        logic [7:0]  count;
        logic        inner;
        logic        last;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [InDataW-1:0] i_s_axis_tdata = '0;
    logic i_s_axis_tuser = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic o_m_axis_tlast;

    code_block_sort_and_overlap_trim dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the block's stores.
    logic [31:0] blk_addr [MaxBlocks];
    logic [7:0]  blk_count [MaxBlocks];
    logic        blk_compact [MaxBlocks];
    logic [9:0]  blk_id [MaxBlocks];
    logic        blk_inner [MaxBlocks];
    int          sorted_idx [MaxBlocks];
    int          n_loaded = 0;
    int          rd_pos = 0;
    bit          is_sorted = 0;

    t_entry expected_entries[$];
    int     n_errors = 0;
    int     n_loads = 0;
    int     n_fetches = 0;
    int     n_results = 0;
    int     n_trimmed = 0;
    bit     hold_off = 0;

    function automatic bit precedes(int x, int y);
        if (blk_addr[x] != blk_addr[y]) return blk_addr[x] < blk_addr[y];
        if (blk_id[x] != blk_id[y]) return blk_id[x] < blk_id[y];
        return x <= y;
    endfunction

    // Stable insertion sort, then trim every block that overlaps its successor.
    function automatic void sort_and_trim();
        int j;
        int key;
        int cur;
        int nxt;
        int sh;
        logic [31:0] end_addr;
        for (int i = 0; i < n_loaded; i++) begin
            key = i;
            j = i - 1;
            while (j >= 0 && !precedes(sorted_idx[j], key)) begin
                sorted_idx[j + 1] = sorted_idx[j];
                j--;
            end
            sorted_idx[j + 1] = key;
        end
        for (int i = 0; i < n_loaded; i++) blk_inner[i] = 1'b0;
        for (int i = 0; i + 1 < n_loaded; i++) begin
            cur = sorted_idx[i];
            nxt = sorted_idx[i + 1];
            sh = blk_compact[cur] ? 1 : 2;
            end_addr = blk_addr[cur] + (32'(blk_count[cur]) << sh);
            if (end_addr > blk_addr[nxt]) begin
                blk_inner[cur] = 1'b1;
                blk_count[cur] = 8'((blk_addr[nxt] - blk_addr[cur]) >> sh);
                n_trimmed++;
            end
        end
        is_sorted = 1;
    endfunction

    function automatic void predict(logic act, logic [InDataW-1:0] d);
        t_entry e;
        int k;
        if (act == ActLoad) begin
            if (is_sorted) begin
                n_loaded = 0;
                rd_pos = 0;
                is_sorted = 0;
            end
            if (n_loaded >= MaxBlocks) return;
            blk_addr[n_loaded] = {d[31:1], 1'b0};
            blk_compact[n_loaded] = d[32];
            blk_count[n_loaded] = d[40:33];
            blk_id[n_loaded] = d[50:41];
            blk_inner[n_loaded] = 1'b0;
            n_loaded++;
            return;
        end
        if (!is_sorted) sort_and_trim();
        if (rd_pos >= n_loaded) return;
        k = sorted_idx[rd_pos];
        e.id = blk_id[k];
        e.addr = blk_addr[k];
        e.compact = blk_compact[k];
        e.count = blk_count[k];
        e.inner = blk_inner[k];
        e.last = (rd_pos + 1 == n_loaded);
        expected_entries.push_back(e);
        rd_pos++;
    endfunction

    // Send one transaction; valid drops for a random gap when a burst ends.
    int burst_left = 0;
    task automatic send_item(logic act, logic [31:0] addr, logic cmp,
                             logic [7:0] cnt, logic [9:0] id);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= act;
        i_s_axis_tdata <= {5'b0, id, cnt, cmp, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict(act, {5'b0, id, cnt, cmp, addr});
        if (act == ActLoad) n_loads++; else n_fetches++;
    endtask

    task automatic load_block(logic [31:0] a, logic c, logic [7:0] n, logic [9:0] id);
        send_item(ActLoad, a, c, n, id);
    endtask

    task automatic fetch_entry();
        send_item(ActFetch, $urandom, 1'($urandom_range(0, 1)), 8'($urandom),
                  10'($urandom));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_entry got;
        t_entry want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[9:0], o_m_axis_tdata[41:10], o_m_axis_tdata[42],
                   o_m_axis_tdata[50:43], o_m_axis_tdata[51], o_m_axis_tlast};
            n_results++;
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                n_errors++;
            end else begin
                want = expected_entries.pop_front();
                if (got.id != want.id) begin
                    $display("%0t: block id exp %h got %h", $realtime, want.id, got.id);
                    n_errors++;
                end
                if (got.addr != want.addr) begin
                    $display("%0t: address exp %h got %h", $realtime, want.addr, got.addr);
                    n_errors++;
                end
                if (got.compact != want.compact) begin
                    $display("%0t: compact exp %b got %b", $realtime, want.compact,
                             got.compact);
                    n_errors++;
                end
                if (got.count != want.count) begin
                    $display("%0t: count exp %h got %h", $realtime, want.count, got.count);
                    n_errors++;
                end
                if (got.inner != want.inner) begin
                    $display("%0t: has_inner exp %b got %b", $realtime, want.inner,
                             got.inner);
                    n_errors++;
                end
                if (got.last != want.last) begin
                    $display("%0t: last exp %b got %b", $realtime, want.last, got.last);
                    n_errors++;
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 37;
        if (hold_off) i_m_axis_tready <= 1'b0;
        else if (stall_phase < 12) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic hold_off_receiver();
        int cycles;
        cycles = 0;
        hold_off = 1;
        while (cycles < 300) begin
            @(posedge i_clk);
            cycles++;
        end
        hold_off = 0;
    endtask

    // Stop offering items and wait for every predicted result.
    task automatic drain_all();
        i_s_axis_tvalid <= 1'b0;
        while (expected_entries.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        fetch_entry();                              // empty set
        load_block(32'hFFFF_FFFF, 1'b0, 8'hFF, 10'h3FF);
        load_block(32'h0000_0000, 1'b1, 8'h00, 10'h000);
        load_block(32'h0000_0000, 1'b0, 8'h10, 10'h000); // equal address and id
        load_block(32'h0000_0010, 1'b1, 8'hFF, 10'h005); // overlaps next
        load_block(32'h0000_0020, 1'b0, 8'h04, 10'h200);
        load_block(32'h0000_0020, 1'b0, 8'h01, 10'h100); // tie broken by id
        load_block(32'hFFFF_FFF0, 1'b0, 8'h08, 10'h010); // end wraps past zero
        load_block(32'h5555_5555, 1'b1, 8'hAA, 10'h2AA);
        repeat (10) fetch_entry();                  // two past the end
        load_block(32'h0000_1000, 1'b0, 8'h02, 10'h001); // new set after sorting
        fetch_entry();
        fetch_entry();
        drain_all();
    endtask

    task automatic test_random_sets();
        int n_set;
        int n_fetch;
        logic [31:0] base;
        while (n_loads + n_fetches < 100) begin
            n_set = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(1, 10);
            base = $urandom;
            for (int i = 0; i < n_set; i++) begin
                if ($urandom_range(0, 2) == 0)
                    load_block($urandom, 1'($urandom_range(0, 1)), 8'($urandom),
                               10'($urandom));
                else
                    load_block(base + $urandom_range(0, 512), 1'($urandom_range(0, 1)),
                               8'($urandom), 10'($urandom_range(0, 7)));
            end
            n_fetch = n_set + $urandom_range(0, 2) - (($urandom_range(0, 4) == 0) ? 2 : 0);
            for (int i = 0; i < n_fetch; i++) fetch_entry();
        end
        drain_all();
    endtask

    task automatic test_backpressure();
        fork
            hold_off_receiver();
            begin
                for (int i = 0; i < 6; i++)
                    load_block($urandom, 1'($urandom_range(0, 1)), 8'($urandom),
                               10'($urandom));
                repeat (6) fetch_entry();
            end
        join
        drain_all();
    endtask

    task automatic test_full_store();
        for (int i = 0; i < MaxBlocks + 2; i++)
            load_block($urandom_range(0, 255) * 4, 1'b0, 8'($urandom_range(0, 3)),
                       10'(i));
        repeat (4) fetch_entry();
        drain_all();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_backpressure();
        test_random_sets();
        test_full_store();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d loads and %0d fetches, %0d results, %0d trimmed blocks.",
                 n_loads, n_fetches, n_results, n_trimmed);
        if (n_errors == 0 && expected_entries.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
